// File: src/fsfa_pkg.sv
package fsfa_pkg;

   // Pool geometry. At most 256 slots are usable, as a slot index has 8 bits.
   localparam int SLOT_COUNT   = 256;
   localparam int USABLE_SLOTS = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
   localparam int LINK_AW      = $clog2(USABLE_SLOTS);

   // Field widths.
   localparam int IDX_W  = 8;
   localparam int LIVE_W = 9;
   localparam int SIZE_W = 13;
   localparam int OFF_W  = 20;
   localparam int PROD_W = IDX_W + SIZE_W;

   // Request codes.
   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_DRY   = 2'd2;

   // Status codes.
   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_EXHAUST = 2'd1;
   localparam logic [1:0] STAT_IGNORED = 2'd2;

   // Slot size limits and live count ceiling.
   localparam logic [SIZE_W-1:0] SIZE_MIN  = 13'd8;
   localparam logic [SIZE_W-1:0] SIZE_MAX  = 13'd4096;
   localparam logic [LIVE_W-1:0] LIVE_MAX  = 9'd511;
   localparam logic [LIVE_W-1:0] FRESH_END = LIVE_W'(USABLE_SLOTS);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;       // a request transfer happens this cycle
      logic link_load;  // the link read for a pop is ready to load
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;   // the result register can take a new result
      logic pop_req;    // the waiting request pops the free list
   } dp_status_type;

endpackage

// File: src/fsfa_ctrl.sv
module fsfa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fsfa_pkg::dp_status_type status,
   output fsfa_pkg::ctrl_cmd_type  cmd
);
   import fsfa_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LINK = 1'b1;

   logic state_ff;
   logic state_in;

   // A request is taken only when idle and the result register has room.
   assign req_ready     = (state_ff == ST_IDLE) && status.out_free;
   assign cmd.take      = req_valid && req_ready;
   assign cmd.link_load = (state_ff == ST_LINK);

   // A pop waits in ST_LINK for the next link to come out of the link memory.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take && status.pop_req) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/fsfa_dp.sv
module fsfa_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  fsfa_pkg::ctrl_cmd_type       cmd,
   output fsfa_pkg::dp_status_type      status,
   input  logic [1:0]                  req_type,
   input  logic [fsfa_pkg::IDX_W-1:0]  req_free_index,
   input  logic                        req_free_is_null,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [fsfa_pkg::IDX_W-1:0]  rsp_slot_index,
   output logic [fsfa_pkg::OFF_W-1:0]  rsp_byte_offset,
   output logic [1:0]                  rsp_status,
   output logic [fsfa_pkg::LIVE_W-1:0] rsp_live_count,
   input  logic                        csr_we,
   input  logic [fsfa_pkg::SIZE_W-1:0] csr_wdata
);
   import fsfa_pkg::*;

   // Link memory: each entry holds the next free slot and whether it exists.
   logic [IDX_W:0] link_mem [USABLE_SLOTS];
   logic [IDX_W:0] link_rd_ff;
   logic           link_we;

   logic [IDX_W-1:0]  head_ff, head_in;
   logic              head_valid_ff, head_valid_in;
   logic [LIVE_W-1:0] fresh_ff, fresh_in;
   logic [LIVE_W-1:0] live_ff, live_in;
   logic [SIZE_W-1:0] size_ff;

   logic [IDX_W-1:0]  slot;
   logic [1:0]        stat;
   logic              granted;
   logic [PROD_W-1:0] product;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_slot_ff;
   logic [OFF_W-1:0]  rsp_off_ff;
   logic [1:0]        rsp_stat_ff;
   logic [LIVE_W-1:0] rsp_live_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.pop_req  = (req_type == REQ_ALLOC) && head_valid_ff;

   // Slot size register, clamped to the legal range when written.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_MIN;
      end else if (csr_we) begin
         if (csr_wdata < SIZE_MIN) begin
            size_ff <= SIZE_MIN;
         end else if (csr_wdata > SIZE_MAX) begin
            size_ff <= SIZE_MAX;
         end else begin
            size_ff <= csr_wdata;
         end
      end
   end

   // Request decode and next pool state.
   always_comb begin
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      fresh_in      = fresh_ff;
      live_in       = live_ff;
      slot          = '0;
      stat          = STAT_DONE;
      granted       = 1'b0;
      link_we       = 1'b0;
      unique case (req_type)
         REQ_ALLOC: begin
            if (head_valid_ff) begin
               slot    = head_ff;
               granted = 1'b1;
            end else if (fresh_ff < FRESH_END) begin
               slot     = fresh_ff[IDX_W-1:0];
               fresh_in = fresh_ff + 1'b1;
               granted  = 1'b1;
            end else begin
               stat = STAT_EXHAUST;
            end
            if (granted && (live_ff < LIVE_MAX)) begin
               live_in = live_ff + 1'b1;
            end
         end
         REQ_FREE: begin
            if (req_free_is_null || (LIVE_W'(req_free_index) >= FRESH_END)) begin
               stat = STAT_IGNORED;
            end else begin
               link_we       = 1'b1;
               head_in       = req_free_index;
               head_valid_in = 1'b1;
               if (live_ff != '0) begin
                  live_in = live_ff - 1'b1;
               end
            end
         end
         REQ_DRY: begin
            head_in       = '0;
            head_valid_in = 1'b0;
            fresh_in      = '0;
         end
         default: begin
         end
      endcase
      // The popped head is replaced once its link has been read.
      if (cmd.link_load) begin
         head_in       = link_rd_ff[IDX_W-1:0];
         head_valid_in = link_rd_ff[IDX_W];
      end
   end

   assign product = PROD_W'(slot) * PROD_W'(size_ff);

   // Pool state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         head_valid_ff <= 1'b0;
         fresh_ff      <= '0;
         live_ff       <= '0;
      end else if (cmd.take || cmd.link_load) begin
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         if (cmd.take) begin
            fresh_ff <= fresh_in;
            live_ff  <= live_in;
         end
      end
   end

   // Link memory: a push writes the old head, a pop reads the head's link.
   always_ff @(posedge clock) begin
      if (cmd.take && link_we) begin
         link_mem[req_free_index[LINK_AW-1:0]] <= {head_valid_ff, head_ff};
      end
      if (cmd.take) begin
         link_rd_ff <= link_mem[head_ff[LINK_AW-1:0]];
      end
   end

   // Result register, loaded with every request transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rsp_slot_ff <= slot;
         rsp_off_ff  <= product[OFF_W-1:0];
         rsp_stat_ff <= stat;
         rsp_live_ff <= live_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_byte_offset = rsp_off_ff;
   assign rsp_status      = rsp_stat_ff;
   assign rsp_live_count  = rsp_live_ff;

endmodule

// File: src/fixed_slot_free_list_allocator.sv
// Fixed-size slot pool with a LIFO free list. Allocate pops the list head or,
// with the list empty, hands out the next never-used slot in ascending order;
// free pushes a slot onto the head; dry-up empties the list and forgets the
// carved slots while keeping the live count. Each request gives one result
// with slot index, byte offset (index times the clamped slot size), status
// and live count. An allocate served from the free list holds off the next
// request until the next link comes out of the registered link memory, in
// the cycle after the read. Results pass through an output register, so a new
// request is taken while the last result is being taken.
module fixed_slot_free_list_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_type,
   input  logic [fsfa_pkg::IDX_W-1:0]  req_free_index,
   input  logic                        req_free_is_null,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [fsfa_pkg::IDX_W-1:0]  rsp_slot_index,
   output logic [fsfa_pkg::OFF_W-1:0]  rsp_byte_offset,
   output logic [1:0]                  rsp_status,
   output logic [fsfa_pkg::LIVE_W-1:0] rsp_live_count,
   input  logic                        csr_we,
   input  logic [fsfa_pkg::SIZE_W-1:0] csr_wdata
);
   import fsfa_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencing of request transfers and pops.
   fsfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Pool state, link memory and result register.
   fsfa_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_type         (req_type),
      .req_free_index   (req_free_index),
      .req_free_is_null (req_free_is_null),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_status       (rsp_status),
      .rsp_live_count   (rsp_live_count),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

endmodule
